// File: hdl/rsu_pkg.sv
// Shared types and constants of the stereo resampler.
package rsu_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = 24;
  localparam int PHASE_W  = 25;
  localparam int FR_W     = FRAC_W + 1;
  localparam int CNT_W    = 6;
  localparam int MAX_OUT  = 64;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(32'd1 << FRAC_W);
  localparam logic [STEP_W-1:0]  MIN_STEP  = STEP_W'((32'd1 << FRAC_W) / MAX_OUT);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(32'd1 << FRAC_W);
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_OUT - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } rsu_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_of_run;
  } rsu_out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } rsu_issue_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] p;
    logic signed [SAMPLE_W-1:0] n;
    logic [FR_W-1:0]            frac;
  } rsu_lane_op_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FIRST,
    SEQ_RUN
  } rsu_state_t;

endpackage

// File: hdl/rsu_seq.sv
// Phase sequencer: accepts requests, walks the output phases, issues lane operations.
module rsu_seq
  import rsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rsu_in_t             in_data,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STEP_W-1:0]   cfg_data,
  input  logic                adv,
  output rsu_issue_t          issue,
  output rsu_lane_op_t        op_left,
  output rsu_lane_op_t        op_right
);

  rsu_state_t state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               have_prior_r, have_prior_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic signed [SAMPLE_W-1:0] prior_left_r, prior_left_nxt;
  logic signed [SAMPLE_W-1:0] prior_right_r, prior_right_nxt;
  rsu_in_t            cur_r, cur_nxt;

  logic               in_acc;
  logic [STEP_W-1:0]  step_eff;
  logic [PHASE_W-1:0] phase_add;
  logic               over_one;
  logic               run_last;

  assign in_acc    = in_valid && !in_stall;
  assign step_eff  = (step_r < MIN_STEP) ? MIN_STEP : step_r;
  assign phase_add = phase_r + PHASE_W'(step_eff);
  assign over_one  = phase_r > PHASE_ONE;
  assign run_last  = (phase_add > PHASE_ONE) || (cnt_r == CNT_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_acc && !have_prior_r) begin
          state_nxt = SEQ_FIRST;
        end else if (in_acc && !over_one) begin
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_FIRST: begin
        if (adv) begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_RUN: begin
        if (adv && run_last) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall       = 1'b1;
    cfg_ready      = 1'b0;
    issue          = '0;
    op_left.p      = prior_left_r;
    op_right.p     = prior_right_r;
    op_left.n      = cur_r.left_in;
    op_right.n     = cur_r.right_in;
    op_left.frac   = phase_r[FR_W-1:0];
    op_right.frac  = phase_r[FR_W-1:0];
    unique case (state_r)
      SEQ_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      SEQ_FIRST: begin
        // first sample passes through: both ends equal, fraction zero
        issue.valid   = adv;
        issue.last    = 1'b1;
        op_left.p     = cur_r.left_in;
        op_right.p    = cur_r.right_in;
        op_left.frac  = '0;
        op_right.frac = '0;
      end
      SEQ_RUN: begin
        issue.valid = adv;
        issue.last  = run_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath state
  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    have_prior_nxt  = have_prior_r;
    step_nxt        = step_r;
    prior_left_nxt  = prior_left_r;
    prior_right_nxt = prior_right_r;
    cur_nxt         = cur_r;
    if (cfg_valid && cfg_ready) begin
      step_nxt = cfg_data;
    end
    priority if (in_acc) begin
      cur_nxt = in_data;
      if (have_prior_r && over_one) begin
        // no output phase in this interval: drop one and replace the prior
        phase_nxt       = phase_r - PHASE_ONE;
        prior_left_nxt  = in_data.left_in;
        prior_right_nxt = in_data.right_in;
      end
    end else if (state_r == SEQ_FIRST && adv) begin
      have_prior_nxt  = 1'b1;
      prior_left_nxt  = cur_r.left_in;
      prior_right_nxt = cur_r.right_in;
      phase_nxt       = PHASE_W'(step_eff);
    end else if (state_r == SEQ_RUN && adv) begin
      cnt_nxt   = cnt_r + CNT_W'(1);
      phase_nxt = phase_add;
      if (run_last) begin
        cnt_nxt         = '0;
        prior_left_nxt  = cur_r.left_in;
        prior_right_nxt = cur_r.right_in;
        phase_nxt       = (phase_add > PHASE_ONE) ? (phase_add - PHASE_ONE) : '0;
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SEQ_IDLE;
      phase_r       <= '0;
      cnt_r         <= '0;
      have_prior_r  <= 1'b0;
      step_r        <= STEP_RST;
      prior_left_r  <= '0;
      prior_right_r <= '0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      have_prior_r  <= have_prior_nxt;
      step_r        <= step_nxt;
      prior_left_r  <= prior_left_nxt;
      prior_right_r <= prior_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// File: hdl/rsu_lane.sv
// One interpolation lane: registered product of difference and fraction, then floor and add.
module rsu_lane
  import rsu_pkg::*;
(
  input  logic                       clk,
  input  logic                       adv,
  input  rsu_lane_op_t               op,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FR_W + 1;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] p_r;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [PROD_W-1:0]   sum;

  assign diff = DIFF_W'(op.n) - DIFF_W'(op.p);
  assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, op.frac}));

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod;
      p_r    <= op.p;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_r >>> FRAC_W;
  assign sum     = shifted + PROD_W'(p_r);
  assign result  = sum[SAMPLE_W-1:0];

endmodule

// File: hdl/rsu_merge.sv
// Merge stage: pairs the lane results with the run marker and holds the output register.
module rsu_merge
  import rsu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsu_issue_t                 issue,
  input  logic signed [SAMPLE_W-1:0] left_res,
  input  logic signed [SAMPLE_W-1:0] right_res,
  input  logic                       out_stall,
  output logic                       adv,
  output logic                       out_valid,
  output rsu_out_t                   out_data
);

  logic     s1_valid_r;
  logic     s1_last_r;
  logic     out_valid_r;
  rsu_out_t out_data_r;

  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue.valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r              <= issue.last;
      out_data_r.left_out    <= left_res;
      out_data_r.right_out   <= right_res;
      out_data_r.last_of_run <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/stereo_linear_resampler_unit.sv
// Stereo linear-interpolation resampler, top level.
//
// Input channel in_valid / in_stall / in_data carries one stereo request
// (left_in, right_in). Output channel out_valid / out_stall / out_data gives
// interpolated stereo samples; last_of_run flags the final sample a request
// produced. A request that produces no sample (downsampling) is absorbed in
// its accept cycle. cfg_valid / cfg_ready / cfg_data writes phase_step
// (8.16 input samples per output); write it only while the block is idle.
//
// After the accept, the first sample of a request passes the sequencer
// state, the lane product register and the output register. Throughput: one
// request at a time, one output per cycle while the pipeline advances; the
// phase sequencer issuing one phase per cycle sets this rate. Two lanes,
// one per channel, share each phase; the merge stage joins them.
// Reset (synchronous, rst_n low) empties the pipeline, sets phase_step to
// 1.0, and makes the next request pass through unchanged. When out_stall
// is high with a sample in the output register, the pipeline and the
// sequencer hold; in_stall stays high until a request's last phase issues.
module stereo_linear_resampler_unit
  import rsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rsu_in_t             in_data,
  output logic                in_stall,
  output logic                out_valid,
  output rsu_out_t            out_data,
  input  logic                out_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STEP_W-1:0]   cfg_data
);

  logic                       adv;
  rsu_issue_t                 issue;
  rsu_lane_op_t               op_left;
  rsu_lane_op_t               op_right;
  logic signed [SAMPLE_W-1:0] left_res;
  logic signed [SAMPLE_W-1:0] right_res;

  // walk phases, one lane operation per cycle while adv is high
  rsu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .issue     (issue),
    .op_left   (op_left),
    .op_right  (op_right)
  );

  // left and right lanes run the same phase side by side
  rsu_lane u_lane_left (
    .clk    (clk),
    .adv    (adv),
    .op     (op_left),
    .result (left_res)
  );

  rsu_lane u_lane_right (
    .clk    (clk),
    .adv    (adv),
    .op     (op_right),
    .result (right_res)
  );

  // join lanes, hold the output register against out_stall
  rsu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .left_res  (left_res),
    .right_res (right_res),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hdl/rsu_checker.sv
// Port-level checks of the stereo resampler, bound to the top level.
module rsu_checker
  import rsu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input rsu_out_t          out_data,
  input logic              out_stall,
  input logic              cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // config port opens exactly when the input side is idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready != in_stall)
    else $error("config ready while busy");

  // a run that is not finished keeps producing or keeps the input blocked
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=> out_valid || in_stall)
    else $error("run ended without last marker");

endmodule

bind stereo_linear_resampler_unit rsu_checker u_rsu_checker (.*);
